@@ rtl/isrt_pkg.sv @@
// ----------------------------------------------------------------------------
// isrt_pkg: shared types and constants of the insertion sorter
// Data width, the per-cell control bundle and the sorter's state codes.
// ----------------------------------------------------------------------------
package isrt_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] isrt_data_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic ins;  // insert the broadcast value this cycle
    logic shl;  // shift the row one cell toward the output
  } isrt_ctrl_t;

  typedef enum logic {
    ST_LOAD = 1'b0,
    ST_EMIT = 1'b1
  } isrt_state_t;

endpackage

@@ rtl/isrt_cell.sv @@
// ----------------------------------------------------------------------------
// isrt_cell: one compare-and-shift cell of the sorting chain
// Holds one stored value; opens a gap for an insert or shifts toward the out end.
// ----------------------------------------------------------------------------
module isrt_cell
  import isrt_pkg::*;
(
  input  logic       clk,
  input  isrt_ctrl_t ctrl,
  input  isrt_data_t ins_value,   // broadcast value being inserted
  input  logic       occ,         // this cell holds a stored value
  input  logic       at_fill,     // this cell is the first free one
  input  isrt_data_t prev_value,  // neighbor closer to the output
  input  logic       prev_gt,
  input  isrt_data_t next_value,  // neighbor farther from the output
  output isrt_data_t value,
  output logic       gt
);

  isrt_data_t value_r;
  isrt_data_t value_nxt;

  // Strictly greater keeps equal values in arrival order
  assign gt    = occ && (value_r > ins_value);
  assign value = value_r;

  always_comb begin
    value_nxt = value_r;
    if (ctrl.ins && (gt || at_fill)) begin
      value_nxt = prev_gt ? prev_value : ins_value;
    end else if (ctrl.shl) begin
      value_nxt = next_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

@@ rtl/insertion_sorter_top.sv @@
// ----------------------------------------------------------------------------
// insertion_sorter_top: stable insertion sorter for signed 32-bit values
// A row of CAPACITY compare-and-shift cells keeps the data set in order.
// ----------------------------------------------------------------------------
// Each accepted input item is inserted into the cell row in the cycle it is
// taken: every cell compares its value with the incoming one in parallel, and
// cells holding greater values move one place to make room, so input runs at
// one item per clock while loading. Equal values keep arrival order. The item
// with tlast set is inserted too unless the row is full, then the block emits
// the whole set smallest first, one result per cycle of out_tready, shifting
// the row toward cell 0; tlast marks the final result and tuser on that result
// flags values dropped because the row was full. A set of N values is taken as
// N input items and emitted as one result per stored value (at most CAPACITY);
// no input is taken while a set drains. No clearing is needed after reset.
// ----------------------------------------------------------------------------
module insertion_sorter_top
  import isrt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,   // last element of the data set
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value_res
  output logic        out_tlast,  // last_res
  output logic [0:0]  out_tuser   // [0] dropped
);

  localparam int CW = $clog2(CAPACITY + 1);

  isrt_state_t state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          ovf_r, ovf_nxt;

  logic       in_acc, out_acc, full, fin;
  isrt_ctrl_t ctrl;
  isrt_data_t ins_value;

  isrt_data_t cell_val [CAPACITY];
  logic       cell_gt  [CAPACITY];

  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign full      = (fill_r == CW'(CAPACITY));
  assign fin       = (fill_r == CW'(1));
  assign ins_value = isrt_data_t'(in_tdata);

  assign ctrl.ins  = in_acc && !full;
  assign ctrl.shl  = out_acc;

  // the cell chain; cell 0 is the output end
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    isrt_data_t prev_v, next_v;
    logic       prev_g;
    if (i == 0) begin : g_head
      assign prev_v = ins_value;
      assign prev_g = 1'b0;
    end else begin : g_body
      assign prev_v = cell_val[i-1];
      assign prev_g = cell_gt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_v = cell_val[i];
    end else begin : g_mid
      assign next_v = cell_val[i+1];
    end

    isrt_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .ins_value  (ins_value),
      .occ        (CW'(i) < fill_r),
      .at_fill    (CW'(i) == fill_r),
      .prev_value (prev_v),
      .prev_gt    (prev_g),
      .next_value (next_v),
      .value      (cell_val[i]),
      .gt         (cell_gt[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: if (in_acc && in_tlast) state_nxt = ST_EMIT;
      ST_EMIT: if (out_acc && fin)     state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      ST_LOAD: in_tready  = 1'b1;
      ST_EMIT: out_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign out_tdata    = cell_val[0];
  assign out_tlast    = fin;
  assign out_tuser[0] = fin && ovf_r;

  // fill count doubles as the remaining count while draining
  always_comb begin
    fill_nxt = fill_r;
    ovf_nxt  = ovf_r;
    if (ctrl.ins)           fill_nxt = fill_r + CW'(1);
    if (out_acc)            fill_nxt = fill_r - CW'(1);
    if (in_acc && full)     ovf_nxt  = 1'b1;
    if (out_acc && fin)     ovf_nxt  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      fill_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // draining never starts or runs with an empty row
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (fill_r != '0))
    else $error("draining with empty cell row");

  // the row never holds more than its capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  // the final result leaves the block empty and clean for the next set
  a_set_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && fin) |=> (fill_r == '0 && !ovf_r && state_r == ST_LOAD))
    else $error("state not cleared after final result");

  // a full row rejects the value it is offered
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && full) |=> (fill_r == CW'(CAPACITY) && ovf_r))
    else $error("insert into full row");

endmodule
